// ===== hdl/ymbr_pkg.sv =====
// ----------------------------------------------------------------------------
// ymbr_pkg: shared types and constants
// Protocol byte codes, result kinds and codes, and the CRC byte step.
// ----------------------------------------------------------------------------
package ymbr_pkg;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_VERD   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] VERD_COMMIT = 2'd0;
  localparam logic [1:0] VERD_CRC    = 2'd1;
  localparam logic [1:0] VERD_ABORT  = 2'd2;
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_HDR    = 2'd1;
  localparam logic [1:0] STAT_FERR   = 2'd2;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CRC = 8'h43;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       keep;
    logic [1:0] code;
    logic       last;
  } res_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ymbr_if.sv =====
// ----------------------------------------------------------------------------
// ymbr_in_if / ymbr_out_if: valid-ready channels
// Input words carry func and rx_byte; result words carry one result.
// ----------------------------------------------------------------------------
interface ymbr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  modport source (output valid, func, rx_byte, input ready);
  modport sink (input valid, func, rx_byte, output ready);
endinterface

interface ymbr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic        keep;
  logic [1:0]  code;
  logic [31:0] done_bytes;
  logic        last;
  modport source (output valid, kind, value, keep, code, done_bytes, last, input ready);
  modport sink (input valid, kind, value, keep, code, done_bytes, last, output ready);
endinterface

// ===== hdl/ymodem_block_receiver.sv =====
// ----------------------------------------------------------------------------
// ymodem_block_receiver: receiving side of YMODEM with CRC-16 blocks
// Packet hunt, CRC check, size parse, data trimming and session control.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per event: a received byte, a timeout tick or a
//   start command. out_ch delivers the result words that each event causes
//   (up to four), the final one marked by last.
//   All state updates for an input word happen in the cycle it is accepted;
//   its results are latched into a small result buffer and drained one word
//   per cycle while out_ch is ready. The block accepts one word per cycle as
//   long as each makes at most one result and out_ch is ready. A word with
//   several results holds the input until its last result is delivered,
//   since the buffer frees one slot per delivered word.
//   The next word is accepted in the same cycle as the last pending result
//   leaves, so an output register never stalls the stream by itself.
//   After reset the session is idle, every counter is zero, and bytes and
//   ticks are ignored until a start command arrives.
//   When out_ch stalls, pending results hold and in_ch.ready stays low.
//   done_bytes is the committed count at the moment each result is made.
// ----------------------------------------------------------------------------
module ymodem_block_receiver
  import ymbr_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ymbr_in_if.sink    in_ch,
  ymbr_out_if.source out_ch
);

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [10:0] LONG_LEN  = 11'd1024;

  localparam logic [1:0] SP_IDLE = 2'd0;
  localparam logic [1:0] SP_HDR  = 2'd1;
  localparam logic [1:0] SP_FILE = 2'd2;
  localparam logic [1:0] SP_END  = 2'd3;

  localparam logic [2:0] PP_HUNT = 3'd0;
  localparam logic [2:0] PP_BLK  = 3'd1;
  localparam logic [2:0] PP_CMP  = 3'd2;
  localparam logic [2:0] PP_DATA = 3'd3;
  localparam logic [2:0] PP_CRCH = 3'd4;
  localparam logic [2:0] PP_CRCL = 3'd5;

  localparam logic [1:0] HS_NAME   = 2'd0;
  localparam logic [1:0] HS_PRE    = 2'd1;
  localparam logic [1:0] HS_DIGITS = 2'd2;
  localparam logic [1:0] HS_DONE   = 2'd3;

  // Kinds of packet that passed every check.
  localparam logic [1:0] GT_SOH = 2'd0;
  localparam logic [1:0] GT_STX = 2'd1;
  localparam logic [1:0] GT_EOT = 2'd2;

  logic [1:0]           sess_r, sess_nxt;
  logic [2:0]           pkt_r, pkt_nxt;
  logic                 long_r, long_nxt;
  logic [7:0]           blk_r, blk_nxt;
  logic [10:0]          idx_r, idx_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           crch_r, crch_nxt;
  logic [1:0]           hs_r, hs_nxt;
  logic [SIZE_BITS-1:0] total_r, total_nxt;
  logic [SIZE_BITS-1:0] comm_r, comm_nxt;

  // Result buffer: up to four words with their done_bytes snapshots.
  res_t        buf_r [MAX_RES];
  logic [31:0] bdone_r [MAX_RES];
  logic [2:0]  cnt_r;
  logic [1:0]  rd_r;

  res_t        res  [MAX_RES];
  logic [31:0] rdone [MAX_RES];
  logic [2:0]  n;

  logic accept;
  logic drain;
  logic [1:0] f;
  logic [7:0] b;

  assign drain  = (cnt_r != 3'd0) && out_ch.ready;
  assign in_ch.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign f = in_ch.func;
  assign b = in_ch.rx_byte;

  // Working values of the size calculations.
  logic [SIZE_BITS+3:0] tot_x10;
  logic [SIZE_BITS-1:0] remain;
  logic [SIZE_BITS-1:0] addv;
  logic [SIZE_BITS:0]   keep_sum;
  logic [3:0]           digit;

  assign digit    = 4'(b - 8'h30);
  assign tot_x10  = ({4'd0, total_r} << 3) + ({4'd0, total_r} << 1) + (SIZE_BITS+4)'(digit);
  assign remain   = total_r - comm_r;
  assign keep_sum = {1'b0, comm_r} + (SIZE_BITS+1)'(idx_r);
  assign addv     = (total_r <= comm_r) ? '0 :
                    (remain > SIZE_BITS'(LONG_LEN)) ? SIZE_BITS'(LONG_LEN) : remain;

  always_comb begin
    logic [1:0] gt;
    logic       good;
    sess_nxt = sess_r; pkt_nxt = pkt_r; long_nxt = long_r; blk_nxt = blk_r;
    idx_nxt = idx_r; crc_nxt = crc_r; crch_nxt = crch_r; hs_nxt = hs_r;
    total_nxt = total_r; comm_nxt = comm_r;
    n = 3'd0;
    gt = GT_SOH;
    good = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
      rdone[i] = 32'(comm_r);
    end

    if (f == FUNC_START) begin
      if (sess_r != SP_IDLE && pkt_r >= PP_DATA) begin
        res[0] = '{KIND_VERD, 8'h00, 1'b0, VERD_ABORT, 1'b0};
        n = 3'd1;
      end
      res[n[1:0]] = '{KIND_TX, B_CRC, 1'b0, CODE_NONE, 1'b0};
      rdone[n[1:0]] = '0;
      n = n + 3'd1;
      sess_nxt = SP_HDR; pkt_nxt = PP_HUNT; long_nxt = 1'b0; blk_nxt = '0;
      idx_nxt = '0; crc_nxt = '0; crch_nxt = '0; hs_nxt = HS_NAME;
      total_nxt = '0; comm_nxt = '0;
    end else if (f == FUNC_TIMEOUT) begin
      if (sess_r != SP_IDLE) begin
        if (pkt_r == PP_HUNT) begin
          res[0] = '{KIND_TX, B_CRC, 1'b0, CODE_NONE, 1'b0};
          n = 3'd1;
        end else begin
          if (pkt_r >= PP_DATA) begin
            res[0] = '{KIND_VERD, 8'h00, 1'b0, VERD_ABORT, 1'b0};
            n = 3'd1;
          end
          pkt_nxt = PP_HUNT;
        end
      end
    end else if (f == FUNC_BYTE && sess_r != SP_IDLE) begin
      unique case (pkt_r)
        PP_HUNT: begin
          if (b == B_SOH || b == B_STX) begin
            long_nxt = (b == B_STX);
            pkt_nxt = PP_BLK;
          end else if (b == B_EOT) begin
            res[0] = '{KIND_TX, B_ACK, 1'b0, CODE_NONE, 1'b0};
            res[1] = '{KIND_TX, B_CRC, 1'b0, CODE_NONE, 1'b0};
            n = 3'd2;
            good = 1'b1;
            gt = GT_EOT;
          end
        end
        PP_BLK: begin
          blk_nxt = b;
          pkt_nxt = PP_CMP;
        end
        PP_CMP: begin
          if ((blk_r ^ b) == 8'hff) begin
            crc_nxt = '0; idx_nxt = '0; pkt_nxt = PP_DATA;
            if (sess_r == SP_HDR && !long_r) begin
              total_nxt = '0; hs_nxt = HS_NAME;
            end
          end else begin
            pkt_nxt = PP_HUNT;
          end
        end
        PP_DATA: begin
          crc_nxt = crc_step(crc_r, b);
          if (sess_r == SP_HDR && !long_r) begin
            if (hs_r == HS_NAME) begin
              if (b == 8'h00) hs_nxt = HS_PRE;
            end else if (hs_r == HS_PRE || hs_r == HS_DIGITS) begin
              if (b >= 8'h30 && b <= 8'h39) begin
                hs_nxt = HS_DIGITS;
                total_nxt = (tot_x10[SIZE_BITS+3:SIZE_BITS] != 4'd0) ? SIZE_MAX
                            : tot_x10[SIZE_BITS-1:0];
              end else if (!(hs_r == HS_PRE && b == 8'h20)) begin
                hs_nxt = HS_DONE;
              end
            end
          end
          if (sess_r == SP_FILE && long_r) begin
            res[0] = '{KIND_DATA, b, (keep_sum < {1'b0, total_r}), CODE_NONE, 1'b0};
            n = 3'd1;
          end
          idx_nxt = idx_r + 11'd1;
          if (idx_nxt >= (long_r ? LONG_LEN : SHORT_LEN)) pkt_nxt = PP_CRCH;
        end
        PP_CRCH: begin
          crch_nxt = b;
          pkt_nxt = PP_CRCL;
        end
        default: begin
          pkt_nxt = PP_HUNT;
          if ({crch_r, b} == crc_r) begin
            res[0] = '{KIND_TX, B_ACK, 1'b0, CODE_NONE, 1'b0};
            n = 3'd1;
            if (!long_r) begin
              res[1] = '{KIND_TX, B_CRC, 1'b0, CODE_NONE, 1'b0};
              n = 3'd2;
            end
            good = 1'b1;
            gt = long_r ? GT_STX : GT_SOH;
          end else begin
            res[0] = '{KIND_TX, B_NAK, 1'b0, CODE_NONE, 1'b0};
            res[1] = '{KIND_VERD, 8'h00, 1'b0, VERD_CRC, 1'b0};
            n = 3'd2;
          end
        end
      endcase
    end

    if (good) begin
      if (sess_r == SP_HDR) begin
        if (gt == GT_SOH) begin
          res[n[1:0]] = '{KIND_VERD, 8'h00, 1'b0, VERD_COMMIT, 1'b0};
          n = n + 3'd1;
          sess_nxt = SP_FILE;
        end else begin
          if (gt == GT_STX) begin
            res[n[1:0]] = '{KIND_VERD, 8'h00, 1'b0, VERD_ABORT, 1'b0};
            n = n + 3'd1;
          end
          res[n[1:0]] = '{KIND_STATUS, 8'h00, 1'b0, STAT_HDR, 1'b0};
          n = n + 3'd1;
          sess_nxt = SP_IDLE;
        end
      end else if (sess_r == SP_FILE) begin
        if (gt == GT_STX) begin
          comm_nxt = comm_r + addv;
          res[n[1:0]] = '{KIND_VERD, 8'h00, 1'b0, VERD_COMMIT, 1'b0};
          rdone[n[1:0]] = 32'(comm_nxt);
          n = n + 3'd1;
        end else if (gt == GT_SOH) begin
          res[n[1:0]] = '{KIND_VERD, 8'h00, 1'b0, VERD_ABORT, 1'b0};
          res[n[1:0] + 2'd1] = '{KIND_STATUS, 8'h00, 1'b0, STAT_FERR, 1'b0};
          n = n + 3'd2;
          sess_nxt = SP_IDLE;
        end else begin
          sess_nxt = SP_END;
        end
      end else begin
        if (gt != GT_EOT) begin
          res[n[1:0]] = '{KIND_VERD, 8'h00, 1'b0, VERD_COMMIT, 1'b0};
          n = n + 3'd1;
        end
        res[n[1:0]] = '{KIND_STATUS, 8'h00, 1'b0, STAT_OK, 1'b0};
        n = n + 3'd1;
        sess_nxt = SP_IDLE;
      end
    end

    if (n != 3'd0) res[2'(n - 3'd1)].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= SP_IDLE; pkt_r <= PP_HUNT; long_r <= 1'b0; blk_r <= '0;
      idx_r <= '0; crc_r <= '0; crch_r <= '0; hs_r <= HS_NAME;
      total_r <= '0; comm_r <= '0;
      cnt_r <= '0; rd_r <= '0;
    end else begin
      if (accept) begin
        sess_r <= sess_nxt; pkt_r <= pkt_nxt; long_r <= long_nxt; blk_r <= blk_nxt;
        idx_r <= idx_nxt; crc_r <= crc_nxt; crch_r <= crch_nxt; hs_r <= hs_nxt;
        total_r <= total_nxt; comm_r <= comm_nxt;
        cnt_r <= n; rd_r <= '0;
      end else if (drain) begin
        cnt_r <= cnt_r - 3'd1;
        rd_r <= rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_r[i]   <= res[i];
        bdone_r[i] <= rdone[i];
      end
    end
  end

  assign out_ch.valid      = (cnt_r != 3'd0);
  assign out_ch.kind       = buf_r[rd_r].kind;
  assign out_ch.value      = buf_r[rd_r].value;
  assign out_ch.keep       = buf_r[rd_r].keep;
  assign out_ch.code       = buf_r[rd_r].code;
  assign out_ch.last       = buf_r[rd_r].last;
  assign out_ch.done_bytes = bdone_r[rd_r];

endmodule
